@@ hdl/apbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the approximate pattern bitap scanner.
// Used by apbs_front, apbs_cell and approximate_pattern_bitap_scan_top.
package apbs_pkg;

    localparam int DEF_MAX_LEVELS   = 5;
    localparam int DEF_ALPHABET     = 32;
    localparam int DEF_PATTERN_BITS = 31;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_TEXT  = 2'd2;

    localparam logic [1:0] REG_PATTERN_LENGTH  = 2'd0;
    localparam logic [1:0] REG_MAX_ERRORS      = 2'd1;
    localparam logic [1:0] REG_ALLOW_INDELS    = 2'd2;
    localparam logic [1:0] REG_OBLIGATORY_MASK = 2'd3;

    localparam int PADDR_W = 4;
    localparam int LEVEL_W = 3;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  symbol;
        logic [30:0] table_mask;
        logic [31:0] start_pos;
    } apbs_in_t;

    typedef struct packed {
        logic [31:0]        hit_pos;
        logic [LEVEL_W-1:0] error_count;
    } apbs_out_t;

    // control part of a word moving along the cell chain
    typedef struct packed {
        logic               valid;
        logic               start;
        logic               found;
        logic [LEVEL_W-1:0] level;
        logic [31:0]        hit_pos;
    } apbs_ctl_t;

endpackage

@@ hdl/approximate_pattern_bitap_scan_top.sv @@
`timescale 1ns / 1ps
// Top level of the approximate pattern bitap scanner: config registers, cell chain, hit register.
// Depends on apbs_pkg, apbs_front and apbs_cell.
//
//   channel   direction  handshake              word
//   item      in         item_valid/item_stall  apbs_in_t  (load, start, text symbol)
//   hit       out        hit_valid/hit_stall    apbs_out_t (start position, error level)
//   config    in         APB psel/penable       4 registers at 4*i
//
// One item per cycle while item_stall is low; one chain cell per error level, so a hit passes
// the front register and every cell register before it reaches the hit register.
// After reset table entries read as zero and rows hold the sentinel of a length-one pattern;
// no clearing pass is needed.
// hit_stall holds the chain, and so item_stall, only while a hit at the chain tail waits
// behind a hit word that is not yet taken.
module approximate_pattern_bitap_scan_top
    import apbs_pkg::*;
#(
    parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
    parameter int ALPHABET     = DEF_ALPHABET,
    parameter int PATTERN_BITS = DEF_PATTERN_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  apbs_in_t           item,
    output logic               hit_valid,
    input  logic               hit_stall,
    output apbs_out_t          hit,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ROW_W  = PATTERN_BITS + 1;
    localparam int PLEN_W = $clog2(PATTERN_BITS + 1);

    logic [4:0]         pattern_length_reg;
    logic [LEVEL_W-1:0] max_errors_reg;
    logic               allow_indels_reg;
    logic [30:0]        obligatory_mask_reg;
    logic               cfg_write;

    logic [PLEN_W-1:0]  plen;
    logic [ROW_W-1:0]   smask;
    logic [ROW_W-1:0]   cmask;
    logic               advance;
    logic               accept;
    logic               tail_hit;

    apbs_ctl_t          ctl_c   [MAX_LEVELS+1];
    logic [ROW_W-1:0]   sindx_c [MAX_LEVELS+1];
    logic [ROW_W-1:0]   old_c   [MAX_LEVELS+1];
    logic [ROW_W-1:0]   new_c   [MAX_LEVELS+1];

    logic               hit_valid_reg;
    apbs_out_t          hit_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg  <= 5'd1;
            max_errors_reg      <= '0;
            allow_indels_reg    <= 1'b0;
            obligatory_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_PATTERN_LENGTH:  pattern_length_reg  <= pwdata[4:0];
                REG_MAX_ERRORS:      max_errors_reg      <= pwdata[LEVEL_W-1:0];
                REG_ALLOW_INDELS:    allow_indels_reg    <= pwdata[0];
                REG_OBLIGATORY_MASK: obligatory_mask_reg <= pwdata[30:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PATTERN_LENGTH:  prdata = 32'(pattern_length_reg);
            REG_MAX_ERRORS:      prdata = 32'(max_errors_reg);
            REG_ALLOW_INDELS:    prdata = 32'(allow_indels_reg);
            REG_OBLIGATORY_MASK: prdata = 32'(obligatory_mask_reg);
            default:             prdata = '0;
        endcase
    end

    assign plen  = (32'(pattern_length_reg) > 32'(PATTERN_BITS)) ? PLEN_W'(PATTERN_BITS)
                                                                  : PLEN_W'(pattern_length_reg);
    assign smask = ROW_W'(1) << plen;
    assign cmask = ~ROW_W'(obligatory_mask_reg);

    assign tail_hit   = ctl_c[MAX_LEVELS].valid && !ctl_c[MAX_LEVELS].start
                        && ctl_c[MAX_LEVELS].found;
    assign advance    = !(tail_hit && hit_valid_reg && hit_stall);
    assign item_stall = !advance;
    assign accept     = item_valid && advance;

    apbs_front #(
        .ALPHABET (ALPHABET),
        .ROW_W    (ROW_W),
        .PLEN_W   (PLEN_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .accept  (accept),
        .item    (item),
        .plen    (plen),
        .ctl     (ctl_c[0]),
        .sindx   (sindx_c[0])
    );

    assign old_c[0] = '0;
    assign new_c[0] = '0;

    for (genvar e = 0; e < MAX_LEVELS; e++)
    begin : g_cell
        apbs_cell #(
            .LEVEL (e),
            .ROW_W (ROW_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .smask      (smask),
            .cmask      (cmask),
            .indel      (allow_indels_reg),
            .max_errors (max_errors_reg),
            .ctl_in     (ctl_c[e]),
            .sindx_in   (sindx_c[e]),
            .old_in     (old_c[e]),
            .new_in     (new_c[e]),
            .ctl_out    (ctl_c[e+1]),
            .sindx_out  (sindx_c[e+1]),
            .old_out    (old_c[e+1]),
            .new_out    (new_c[e+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (tail_hit)
            begin
                hit_valid_reg <= 1'b1;
            end
            else if (!hit_stall)
            begin
                hit_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_hit)
        begin
            hit_reg.hit_pos     <= ctl_c[MAX_LEVELS].hit_pos;
            hit_reg.error_count <= ctl_c[MAX_LEVELS].level;
        end
    end

    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

    a_stall_only_on_blocked_hit: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (hit_valid && hit_stall && tail_hit))
        else $error("item_stall without a blocked hit");

    a_accept_issues_word: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.func == FUNC_START || item.func == FUNC_TEXT))
        |=> ctl_c[0].valid)
        else $error("accepted start or text symbol did not enter the chain");

    a_hit_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hit_valid) |-> $past(tail_hit))
        else $error("hit word appeared without a hit at the chain tail");

    a_start_never_found: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_c[MAX_LEVELS].valid && ctl_c[MAX_LEVELS].start) |-> !ctl_c[MAX_LEVELS].found)
        else $error("start word marked as a hit");

endmodule

@@ hdl/apbs_front.sv @@
`timescale 1ns / 1ps
// Front end: symbol mask table, position counter and word issue into the cell chain.
// Depends on apbs_pkg.
module apbs_front
    import apbs_pkg::*;
#(
    parameter int ALPHABET = DEF_ALPHABET,
    parameter int ROW_W    = DEF_PATTERN_BITS + 1,
    parameter int PLEN_W   = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              accept,
    input  apbs_in_t          item,
    input  logic [PLEN_W-1:0] plen,
    output apbs_ctl_t         ctl,
    output logic [ROW_W-1:0]  sindx
);

    localparam int IDX_W = $clog2(ALPHABET);
    localparam int TAB_W = ROW_W - 1;

    logic [TAB_W-1:0]    mem [ALPHABET];
    logic [ALPHABET-1:0] tab_valid_reg;
    logic [TAB_W-1:0]    rd_data_reg;
    logic                rd_ok_reg;
    logic                rd_ok_next;
    logic [31:0]         position_reg;
    logic [31:0]         position_next;
    apbs_ctl_t           ctl_reg;
    apbs_ctl_t           ctl_next;
    logic [IDX_W-1:0]    idx;
    logic                in_range;
    logic                do_load;

    assign idx      = IDX_W'(item.symbol);
    assign in_range = 32'(item.symbol) < 32'(ALPHABET);
    assign do_load  = accept && (item.func == FUNC_LOAD) && in_range;

    always_comb
    begin
        position_next = position_reg;
        ctl_next      = '0;
        rd_ok_next    = in_range && tab_valid_reg[idx];
        if (accept && item.func == FUNC_START)
        begin
            position_next  = item.start_pos;
            ctl_next.valid = 1'b1;
            ctl_next.start = 1'b1;
        end
        else if (accept && item.func == FUNC_TEXT)
        begin
            position_next    = position_reg + 32'd1;
            ctl_next.valid   = 1'b1;
            ctl_next.hit_pos = position_reg - 32'(plen) + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            mem[idx] <= TAB_W'(item.table_mask);
        end
        if (advance)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
            position_reg  <= '0;
            ctl_reg       <= '0;
        end
        else
        begin
            if (do_load)
            begin
                tab_valid_reg[idx] <= 1'b1;
            end
            position_reg <= position_next;
            if (advance)
            begin
                rd_ok_reg <= rd_ok_next;
                ctl_reg   <= ctl_next;
            end
        end
    end

    assign ctl   = ctl_reg;
    assign sindx = rd_ok_reg ? ROW_W'(rd_data_reg) : '0;

endmodule

@@ hdl/apbs_cell.sv @@
`timescale 1ns / 1ps
// One error level of the bitap chain: holds its row and passes each word to the next level.
// Depends on apbs_pkg.
module apbs_cell
    import apbs_pkg::*;
#(
    parameter int LEVEL = 0,
    parameter int ROW_W = DEF_PATTERN_BITS + 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [ROW_W-1:0]   smask,
    input  logic [ROW_W-1:0]   cmask,
    input  logic               indel,
    input  logic [LEVEL_W-1:0] max_errors,
    input  apbs_ctl_t          ctl_in,
    input  logic [ROW_W-1:0]   sindx_in,
    input  logic [ROW_W-1:0]   old_in,
    input  logic [ROW_W-1:0]   new_in,
    output apbs_ctl_t          ctl_out,
    output logic [ROW_W-1:0]   sindx_out,
    output logic [ROW_W-1:0]   old_out,
    output logic [ROW_W-1:0]   new_out
);

    localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(2);

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [ROW_W-1:0] old_row;
    logic [ROW_W-1:0] carry;
    logic [ROW_W-1:0] nw_row;
    logic [ROW_W-1:0] init_row;
    logic             active;
    apbs_ctl_t        ctl_reg;
    apbs_ctl_t        ctl_next;
    logic [ROW_W-1:0] sindx_reg;
    logic [ROW_W-1:0] old_reg;
    logic [ROW_W-1:0] new_reg;
    logic [ROW_W-1:0] new_next;

    always_comb
    begin
        old_row  = row_reg | smask;
        carry    = indel ? ((old_in | (old_in >> 1) | (new_in >> 1)) & cmask)
                         : ((old_in >> 1) & cmask);
        nw_row   = carry | ((old_row >> 1) & sindx_in);
        init_row = indel ? ((new_in >> 1) | smask) : smask;
        active   = 32'(max_errors) >= 32'(LEVEL);
        row_next = row_reg;
        ctl_next = ctl_in;
        new_next = ctl_in.start ? init_row : nw_row;
        if (ctl_in.valid && ctl_in.start)
        begin
            row_next = init_row;
        end
        else if (ctl_in.valid && active)
        begin
            row_next = nw_row;
            if (!ctl_in.found && nw_row[0])
            begin
                ctl_next.found = 1'b1;
                ctl_next.level = LEVEL_W'(LEVEL);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= ROW_RESET;
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            row_reg <= row_next;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sindx_reg <= sindx_in;
            old_reg   <= old_row;
            new_reg   <= new_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign sindx_out = sindx_reg;
    assign old_out   = old_reg;
    assign new_out   = new_reg;

endmodule

@@ tb/approximate_pattern_bitap_scan_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for approximate_pattern_bitap_scan_top: mask loads, scan starts, text words.
// Compares every hit word, field by field, with a bitap predictor kept in this file; uses apbs_pkg.
module approximate_pattern_bitap_scan_top_tb;
    import apbs_pkg::*;

    localparam int         LEVELS       = DEF_MAX_LEVELS;
    localparam int         DRAIN_CYCLES = DEF_MAX_LEVELS + 6;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         LONG_HOLD    = 200;
    localparam int         RANDOM_WORDS = 400;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid = 1'b0;
    logic               item_stall;
    apbs_in_t           item = '0;
    logic               hit_valid;
    logic               hit_stall = 1'b0;
    apbs_out_t          hit;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    apbs_in_t    pending_words [$];
    apbs_out_t   expected_hits [$];
    int          queued_words = 0;
    int          taken_words = 0;
    int          send_wait = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          rx_wait = 0;
    int          hold_left = 0;
    logic        no_idle = 1'b0;

    logic [4:0]  cfg_len;
    logic [2:0]  cfg_errs;
    logic        cfg_indel;
    logic [30:0] cfg_oblig;
    logic [30:0] mask_store [32];
    logic [31:0] rows [LEVELS];
    logic [31:0] scan_pos;

    approximate_pattern_bitap_scan_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .hit_valid  (hit_valid),
        .hit_stall  (hit_stall),
        .hit        (hit),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch: %s got %h want %h", what, got, want);
    endtask

    task automatic predict_word(input apbs_in_t w);
        logic [31:0] smask, seed, sel, keep, prev_old, prev_new, old_row, carry, new_row;
        int          top, found, e;
        apbs_out_t   res;
        smask = 32'd1 << cfg_len;
        case (w.func)
            FUNC_LOAD: mask_store[w.symbol] = w.table_mask;
            FUNC_START:
            begin
                scan_pos = w.start_pos;
                seed = smask;
                for (e = 0; e < LEVELS; e++)
                begin
                    rows[e] = seed;
                    if (cfg_indel)
                        seed = (seed >> 1) | smask;
                end
            end
            FUNC_TEXT:
            begin
                sel = {1'b0, mask_store[w.symbol]};
                keep = ~{1'b0, cfg_oblig};
                top = (cfg_errs > LEVELS - 1) ? LEVELS - 1 : int'(cfg_errs);
                prev_old = '0;
                prev_new = '0;
                found = -1;
                for (e = 0; e <= top; e++)
                begin
                    old_row = rows[e] | smask;
                    carry = '0;
                    if (e > 0)
                        carry = cfg_indel ? (prev_old | (prev_old >> 1) | (prev_new >> 1)) & keep
                                          : (prev_old >> 1) & keep;
                    new_row = carry | ((old_row >> 1) & sel);
                    prev_old = old_row;
                    prev_new = new_row;
                    rows[e] = new_row;
                    if (found < 0 && new_row[0])
                        found = e;
                end
                if (found >= 0)
                begin
                    res.hit_pos = scan_pos - 32'(cfg_len) + 32'd1;
                    res.error_count = LEVEL_W'(found);
                    expected_hits.push_back(res);
                end
                scan_pos = scan_pos + 32'd1;
            end
            default: ;
        endcase
    endtask

    // sender: one word per handshake, a drawn gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_word(item);
                taken_words++;
            end
            if (item_valid && item_stall)
            begin
                // hold
            end
            else if (send_wait > 0)
            begin
                item_valid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_words.size() > 0)
            begin
                item <= pending_words.pop_front();
                item_valid <= 1'b1;
                send_wait <= no_idle ? 0 : $urandom_range(0, 18);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver: check each hit word, then stall for a drawn count
    always @(posedge clk or negedge rst_n)
    begin : hit_side
        apbs_out_t want;
        if (!rst_n)
        begin
            hit_stall <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (hit_valid && !hit_stall)
            begin
                if (expected_hits.size() == 0)
                    flag_mismatch("hit with none pending, hit_pos", hit.hit_pos, '0);
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit.hit_pos !== want.hit_pos)
                        flag_mismatch("hit_pos", hit.hit_pos, want.hit_pos);
                    if (hit.error_count !== want.error_count)
                        flag_mismatch("error_count", 32'(hit.error_count),
                                      32'(want.error_count));
                end
                rx_wait = no_idle ? 0 : $urandom_range(0, 18);
            end
            else if (rx_wait > 0)
                rx_wait--;
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            else if (hold_left > 0)
                hold_left--;
            hit_stall <= (rx_wait > 0) || (hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (hit_valid && !hit_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PATTERN_LENGTH:  cfg_len = value[4:0];
            REG_MAX_ERRORS:      cfg_errs = value[2:0];
            REG_ALLOW_INDELS:    cfg_indel = value[0];
            REG_OBLIGATORY_MASK: cfg_oblig = value[30:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [31:0] len, input logic [31:0] errs,
                                input logic [31:0] indel, input logic [31:0] oblig);
        write_reg(REG_PATTERN_LENGTH, len);
        write_reg(REG_MAX_ERRORS, errs);
        write_reg(REG_ALLOW_INDELS, indel);
        write_reg(REG_OBLIGATORY_MASK, oblig);
    endtask

    task automatic wait_idle();
        while (taken_words != queued_words || expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_word(input logic [1:0] f, input logic [4:0] s,
                              input logic [30:0] m, input logic [31:0] p);
        apbs_in_t w;
        w.func = f;
        w.symbol = s;
        w.table_mask = m;
        w.start_pos = p;
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic queue_text(input logic [4:0] s);
        queue_word(FUNC_TEXT, s, 31'($urandom), $urandom);
    endtask

    task automatic queue_noise(input logic [4:0] base);
        case ($urandom_range(0, 19))
            0: queue_word(FUNC_UNUSED, 5'($urandom), 31'($urandom), $urandom);
            1: queue_word(FUNC_LOAD, 5'($urandom), 31'($urandom), $urandom);
            2: queue_word(FUNC_START, 5'($urandom), 31'($urandom), $urandom);
            3: queue_text(5'($urandom));
            default: queue_text(base + 5'($urandom_range(0, 3)));
        endcase
    endtask

    // masks for a random pattern over a four-symbol alphabet, a start, then mutated copies
    task automatic queue_scan_set();
        logic [4:0]  base;
        logic [30:0] msk [4];
        logic [31:0] origin;
        int          pat [31];
        int          len, j, k, copies, r;
        len = cfg_len;
        base = 5'($urandom_range(0, 31));
        for (k = 0; k < 4; k++)
            msk[k] = '0;
        for (j = 0; j < len; j++)
        begin
            pat[j] = $urandom_range(0, 3);
            msk[pat[j]] = msk[pat[j]] | (31'(1) << (len - 1 - j));
        end
        for (k = 0; k < 4; k++)
            queue_word(FUNC_LOAD, base + 5'(k), msk[k], $urandom);
        origin = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 20);
        queue_word(FUNC_START, 5'($urandom), 31'($urandom), origin);
        copies = $urandom_range(1, 3);
        for (k = 0; k < copies; k++)
        begin
            repeat ($urandom_range(0, 4)) queue_noise(base);
            for (j = 0; j < len; j++)
            begin
                r = $urandom_range(0, 19);
                if (r == 1)
                    queue_text(base + 5'($urandom_range(0, 3)));
                else if (r != 0)
                begin
                    if (r == 2)
                        queue_text(base + 5'($urandom_range(0, 3)));
                    queue_text(base + 5'(pat[j]));
                end
            end
        end
        repeat ($urandom_range(0, 4)) queue_noise(base);
    endtask

    initial
    begin : stimulus
        logic [31:0] len, errs, oblig;
        int          random_start, k;
        cfg_len = 5'd1;
        cfg_errs = '0;
        cfg_indel = 1'b0;
        cfg_oblig = '0;
        for (k = 0; k < 32; k++)
            mask_store[k] = '0;
        for (k = 0; k < LEVELS; k++)
            rows[k] = 32'd2;
        scan_pos = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: ignored func, text on an empty table
        queue_word(FUNC_UNUSED, 5'd31, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_text(5'd31);
        wait_idle();

        write_config(32'd5, 32'd2, 32'd0, 32'd0);
        queue_word(FUNC_LOAD, 5'd1, 31'h10, $urandom);
        queue_word(FUNC_LOAD, 5'd2, 31'h08, $urandom);
        queue_word(FUNC_LOAD, 5'd3, 31'h04, $urandom);
        queue_word(FUNC_LOAD, 5'd4, 31'h02, $urandom);
        queue_word(FUNC_LOAD, 5'd5, 31'h01, $urandom);
        queue_word(FUNC_LOAD, 5'd0, 31'h7FFF_FFFF, 32'h0);
        queue_word(FUNC_LOAD, 5'd31, 31'h0, 32'hFFFF_FFFF);
        queue_word(FUNC_START, 5'd0, 31'h0, 32'hFFFF_FFFE);
        for (k = 1; k <= 5; k++)
            queue_text(5'(k));
        queue_text(5'd1);
        queue_text(5'd2);
        queue_text(5'd9);
        queue_text(5'd4);
        queue_text(5'd5);
        queue_word(FUNC_START, 5'd31, 31'h7FFF_FFFF, 32'h0);
        repeat (3) queue_text(5'd0);
        wait_idle();

        // fill the block behind a long receiver hold
        write_config(32'd2, 32'd0, 32'd0, 32'd0);
        queue_word(FUNC_LOAD, 5'd7, 31'h7FFF_FFFF, $urandom);
        queue_word(FUNC_START, 5'($urandom), 31'($urandom), $urandom);
        wait_idle();
        no_idle = 1'b1;
        hold_req++;
        repeat (60) queue_text(5'd7);
        wait_idle();
        no_idle = 1'b0;

        random_start = queued_words;
        while (queued_words - random_start < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 7))
                0: len = 32'd0;
                1: len = 32'd31;
                2: len = 32'd1;
                default: len = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 9))
                9: errs = 32'd7;
                8: errs = 32'd4;
                default: errs = $urandom_range(0, 4);
            endcase
            case ($urandom_range(0, 7))
                0: oblig = 32'h7FFF_FFFF;
                1: oblig = $urandom;
                2, 3: oblig = $urandom & ((32'd1 << len) - 32'd1);
                default: oblig = 32'd0;
            endcase
            write_config(len, errs, $urandom_range(0, 1), oblig);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 2)) queue_scan_set();
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
